// ===== rtl/core/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, types and controller/datapath command and status structs for the
// clock (second-chance) page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // Sizes of the page space and the frame pool.
  localparam int NUM_PAGES  = 128;
  localparam int MAX_FRAMES = 128;

  // Field and register widths.
  localparam int PAGE_W  = 7;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 8;
  localparam int LIMIT_W = 8;
  localparam int HITS_W  = 32;

  // Frame limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP
  } cpr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_page;
    logic do_hit;
    logic do_fill;
    logic sweep_start;
    logic sweep_step;
    logic do_evict;
  } cpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic page_hit;
    logic can_fill;
    logic victim_ref;
    logic out_free;
  } cpr_status_t;

endpackage

// ===== rtl/core/cpr_page_if.sv =====
// ----------------------------------------------------------------------------
// cpr_page_if
// Request channel: one page reference per word.
// ----------------------------------------------------------------------------
interface cpr_page_if;
  logic                       valid;
  logic                       ready;
  logic [cpr_pkg::PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

// ===== rtl/core/cpr_result_if.sv =====
// ----------------------------------------------------------------------------
// cpr_result_if
// Response channel: one replacement result per word.
// ----------------------------------------------------------------------------
interface cpr_result_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       evicted;
  logic [cpr_pkg::PAGE_W-1:0] victim_page;
  logic [cpr_pkg::SLOT_W-1:0] frame_slot;
  logic [cpr_pkg::HITS_W-1:0] hit_count;

  modport source (output valid, output hit, output evicted, output victim_page,
                  output frame_slot, output hit_count, input ready);
  modport sink   (input valid, input hit, input evicted, input victim_page,
                  input frame_slot, input hit_count, output ready);
endinterface

// ===== rtl/core/cpr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cpr_cfg_if
// Configuration write channel for the frame limit register.
// ----------------------------------------------------------------------------
interface cpr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cpr_pkg::LIMIT_W-1:0] frame_limit;

  modport source (output valid, output frame_limit, input ready);
  modport sink   (input valid, input frame_limit, output ready);
endinterface

// ===== rtl/core/clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement
// Hits and fills are answered from the decide state. A miss with all frames
// in use starts a sweep: the hand clears referenced frames, at most as many
// as are in use, until it reaches an unreferenced one, which is evicted.
// One word at a time: a new word is taken only once the result of the last
// one has been written; the sweep reads the frame RAM once a cycle. Reset
// (synchronous, active high) clears all page bits, hand and counters.
// ----------------------------------------------------------------------------
module clock_page_replacement (
  input  logic  clk,
  input  logic  rst,
  cpr_page_if.sink     req,
  cpr_result_if.source rsp,
  cpr_cfg_if.sink      cfg
);

  cpr_pkg::cpr_cmd_t    cmd;
  cpr_pkg::cpr_status_t status;

  // The frame limit register takes writes at any time.
  assign cfg.ready = 1'b1;

  // Controller.
  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  cpr_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .page_number     (req.page_number),
    .cfg_valid       (cfg.valid),
    .cfg_frame_limit (cfg.frame_limit),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_hit         (rsp.hit),
    .out_evicted     (rsp.evicted),
    .out_victim_page (rsp.victim_page),
    .out_frame_slot  (rsp.frame_slot),
    .out_hit_count   (rsp.hit_count)
  );

  // At most one datapath action per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_hit, cmd.do_fill, cmd.do_evict, cmd.sweep_start, cmd.sweep_step}))
    else $error("conflicting datapath commands");

  // A result is only written when the result register can take it.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.do_hit || cmd.do_fill || cmd.do_evict) |-> status.out_free)
    else $error("result register overwritten");

  // A new request is not taken while one is in progress.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // A sweep step is always followed by more sweep work, never by a new request.
  assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |=> (!req.ready && !cmd.do_hit && !cmd.do_fill))
    else $error("sweep left early");

endmodule

// ===== rtl/core/cpr_ram.sv =====
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/cpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpr_ctrl
// Controller: sequences lookup, fill and the clock sweep for one reference.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cpr_pkg::cpr_status_t status,
  output cpr_pkg::cpr_cmd_t    cmd
);

  cpr_pkg::cpr_state_t state;
  cpr_pkg::cpr_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cpr_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = cpr_pkg::ST_DECIDE;
        end
      end
      cpr_pkg::ST_DECIDE: begin
        if (status.page_hit || status.can_fill) begin
          if (status.out_free) begin
            state_next = cpr_pkg::ST_IDLE;
          end
        end else begin
          state_next = cpr_pkg::ST_SWEEP;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (!status.victim_ref && status.out_free) begin
          state_next = cpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    case (state)
      cpr_pkg::ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_page = req_valid;
      end
      cpr_pkg::ST_DECIDE: begin
        if (status.page_hit) begin
          cmd.do_hit = status.out_free;
        end else if (status.can_fill) begin
          cmd.do_fill = status.out_free;
        end else begin
          cmd.sweep_start = 1'b1;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (status.victim_ref) begin
          cmd.sweep_step = 1'b1;
        end else begin
          cmd.do_evict = status.out_free;
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/cpr_datapath.sv =====
// ----------------------------------------------------------------------------
// cpr_datapath
// Page tables, frame memory, clock hand, hit counter and the result register.
// ----------------------------------------------------------------------------
module cpr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cpr_pkg::cpr_cmd_t           cmd,
  output cpr_pkg::cpr_status_t        status,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_number,
  input  logic                        cfg_valid,
  input  logic [cpr_pkg::LIMIT_W-1:0] cfg_frame_limit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic                        out_evicted,
  output logic [cpr_pkg::PAGE_W-1:0]  out_victim_page,
  output logic [cpr_pkg::SLOT_W-1:0]  out_frame_slot,
  output logic [cpr_pkg::HITS_W-1:0]  out_hit_count
);

  localparam int PW = cpr_pkg::PAGE_W;
  localparam int SW = cpr_pkg::SLOT_W;
  localparam int CW = cpr_pkg::COUNT_W;
  localparam int LW = cpr_pkg::LIMIT_W;
  localparam int HW = cpr_pkg::HITS_W;

  logic [cpr_pkg::NUM_PAGES-1:0] present;
  logic [cpr_pkg::NUM_PAGES-1:0] referenced;
  logic [PW-1:0]                 page;
  logic [LW-1:0]                 frame_limit;
  logic [CW-1:0]                 frames_used;
  logic [SW-1:0]                 clock_hand;
  logic [SW-1:0]                 sweep_hand;
  logic [HW-1:0]                 hits;
  logic [HW-1:0]                 hits_next;
  logic [CW-1:0]                 eff_limit;
  logic [SW-1:0]                 hand_start;
  logic [SW-1:0]                 hand_adv;
  logic [PW-1:0]                 victim;
  logic                          ram_wr_en;
  logic [SW-1:0]                 ram_wr_addr;
  logic                          ram_rd_en;
  logic [SW-1:0]                 ram_rd_addr;

  // Effective frame limit: zero means one, clamp to the frame pool size.
  always_comb begin
    if (frame_limit == '0) begin
      eff_limit = CW'(1);
    end else if (CW'(frame_limit) > CW'(cpr_pkg::MAX_FRAMES)) begin
      eff_limit = CW'(cpr_pkg::MAX_FRAMES);
    end else begin
      eff_limit = CW'(frame_limit);
    end
  end

  // Hand positions on the ring of occupied frames.
  assign hand_start = (CW'(clock_hand) >= frames_used) ? '0 : clock_hand;
  assign hand_adv   = (CW'(sweep_hand) + CW'(1) == frames_used) ? '0
                                                                : sweep_hand + SW'(1);

  // Saturating hit counter increment.
  assign hits_next = (hits == '1) ? hits : hits + HW'(1);

  // Status to the controller.
  assign status.page_hit   = present[page];
  assign status.can_fill   = (frames_used < eff_limit);
  assign status.victim_ref = referenced[victim];
  assign status.out_free   = !out_valid || out_ready;

  // Frame memory: filled in order, rewritten on eviction, read by the sweep.
  assign ram_wr_en   = cmd.do_fill || cmd.do_evict;
  assign ram_wr_addr = cmd.do_fill ? frames_used[SW-1:0] : sweep_hand;
  assign ram_rd_en   = cmd.sweep_start || cmd.sweep_step;
  assign ram_rd_addr = cmd.sweep_start ? hand_start : hand_adv;

  cpr_ram #(
    .WIDTH (PW),
    .DEPTH (cpr_pkg::MAX_FRAMES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (page),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (victim)
  );

  // Captured page reference.
  always_ff @(posedge clk) begin
    if (cmd.load_page) begin
      page <= page_number;
    end
  end

  // Frame limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= cpr_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      frame_limit <= cfg_frame_limit;
    end
  end

  // Per-page present and referenced bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      referenced <= '0;
    end else begin
      if (cmd.do_hit) begin
        referenced[page] <= 1'b1;
      end
      if (cmd.sweep_step) begin
        referenced[victim] <= 1'b0;
      end
      if (cmd.do_evict) begin
        present[victim]    <= 1'b0;
        referenced[victim] <= 1'b0;
      end
      if (cmd.do_fill || cmd.do_evict) begin
        present[page]    <= 1'b1;
        referenced[page] <= 1'b0;
      end
    end
  end

  // Fill count, clock hand, sweep position and hit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_used <= '0;
      clock_hand  <= '0;
      sweep_hand  <= '0;
      hits        <= '0;
    end else begin
      if (cmd.do_fill) begin
        frames_used <= frames_used + CW'(1);
      end
      if (cmd.sweep_start) begin
        sweep_hand <= hand_start;
      end else if (cmd.sweep_step) begin
        sweep_hand <= hand_adv;
      end
      if (cmd.do_evict) begin
        clock_hand <= hand_adv;
      end
      if (cmd.do_hit) begin
        hits <= hits_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_hit || cmd.do_fill || cmd.do_evict) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.do_hit) begin
      out_hit         <= 1'b1;
      out_evicted     <= 1'b0;
      out_victim_page <= '0;
      out_frame_slot  <= '0;
      out_hit_count   <= hits_next;
    end else if (cmd.do_fill) begin
      out_hit         <= 1'b0;
      out_evicted     <= 1'b0;
      out_victim_page <= '0;
      out_frame_slot  <= frames_used[SW-1:0];
      out_hit_count   <= hits;
    end else if (cmd.do_evict) begin
      out_hit         <= 1'b0;
      out_evicted     <= 1'b1;
      out_victim_page <= victim;
      out_frame_slot  <= sweep_hand;
      out_hit_count   <= hits;
    end
  end

endmodule

// ===== verif/clock_page_replacement_test.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement_test
// Drives page references through the clock replacement block under random
// idling on both channels. A software copy of the frame table predicts hit,
// eviction, victim, slot and hit count for every accepted word, and each
// result word is compared with the oldest prediction. The frame limit is
// rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module clock_page_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result word.
  typedef struct packed {
    logic                       hit;
    logic                       evicted;
    logic [cpr_pkg::PAGE_W-1:0] victim_page;
    logic [cpr_pkg::SLOT_W-1:0] frame_slot;
    logic [cpr_pkg::HITS_W-1:0] hit_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;

  cpr_page_if   page_bus ();
  cpr_result_if result_bus ();
  cpr_cfg_if    cfg_bus ();

  clock_page_replacement dut (
    .clk (clk),
    .rst (rst),
    .req (page_bus),
    .rsp (result_bus),
    .cfg (cfg_bus)
  );

  always #2 clk = ~clk;

  // Shadow copy of the replacement state.
  bit                          page_resident [cpr_pkg::NUM_PAGES];
  bit                          page_recent   [cpr_pkg::NUM_PAGES];
  bit [cpr_pkg::PAGE_W-1:0]    frame_owner   [cpr_pkg::MAX_FRAMES];
  int unsigned                 sweep_hand;
  int unsigned                 frames_in_use;
  bit [cpr_pkg::HITS_W-1:0]    hits_total;
  logic [cpr_pkg::LIMIT_W-1:0] frame_limit_reg = cpr_pkg::LIMIT_RESET;

  bit [cpr_pkg::PAGE_W-1:0] pending_pages [$];
  outcome_t                 awaited_results [$];
  int unsigned              pages_sent;
  int unsigned              errors;
  bit                       page_sent;
  bit                       steady;
  int unsigned              hold_left;
  bit                       hold_done;

  // Applies one page reference to the shadow state and returns its result.
  function automatic outcome_t predict_reference(bit [cpr_pkg::PAGE_W-1:0] pg);
    outcome_t    r;
    int unsigned usable;
    int unsigned ring;
    int unsigned pos;
    bit [cpr_pkg::PAGE_W-1:0] gone;
    r = '0;
    usable = (frame_limit_reg == 0) ? 1 : frame_limit_reg;
    if (usable > cpr_pkg::MAX_FRAMES) usable = cpr_pkg::MAX_FRAMES;
    if (page_resident[pg]) begin
      page_recent[pg] = 1'b1;
      r.hit = 1'b1;
      if (hits_total != '1) hits_total++;
    end else if (frames_in_use < usable) begin
      r.frame_slot = cpr_pkg::SLOT_W'(frames_in_use);
      frame_owner[frames_in_use] = pg;
      frames_in_use++;
      page_resident[pg] = 1'b1;
      page_recent[pg] = 1'b0;
    end else begin
      // Second-chance sweep: clear referenced bits until an unreferenced page.
      ring = frames_in_use;
      pos = (sweep_hand >= ring) ? 0 : sweep_hand;
      for (int n = 0; n < 2 * ring + 1; n++) begin
        if (!page_recent[frame_owner[pos]]) break;
        page_recent[frame_owner[pos]] = 1'b0;
        pos = (pos + 1) % ring;
      end
      gone = frame_owner[pos];
      r.evicted = 1'b1;
      r.victim_page = gone;
      r.frame_slot = cpr_pkg::SLOT_W'(pos);
      page_resident[gone] = 1'b0;
      page_recent[gone] = 1'b0;
      frame_owner[pos] = pg;
      page_resident[pg] = 1'b1;
      page_recent[pg] = 1'b0;
      sweep_hand = (pos + 1) % ring;
    end
    r.hit_count = hits_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Page words accepted at the rising edge are predicted right away.
  always @(posedge clk) begin
    page_sent = 1'b0;
    if (!rst && page_bus.valid && page_bus.ready) begin
      page_sent = 1'b1;
      awaited_results.push_back(predict_reference(page_bus.page_number));
      void'(pending_pages.pop_front());
      pages_sent++;
    end
  end

  // Request driver: holds a word until taken, otherwise offers the next one.
  always @(negedge clk) begin
    if (rst) begin
      page_bus.valid <= 1'b0;
    end else if (!page_bus.valid || page_sent) begin
      if (pending_pages.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
        page_bus.valid <= 1'b1;
        page_bus.page_number <= pending_pages[0];
      end else begin
        page_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off while words keep coming.
  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && pages_sent > 200 && pending_pages.size() >= 100) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      result_bus.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 19);
    end
  end

  // Result monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result word with no reference pending", $time);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(result_bus.hit));
        check_field("evicted", 32'(want.evicted), 32'(result_bus.evicted));
        check_field("victim_page", 32'(want.victim_page), 32'(result_bus.victim_page));
        check_field("frame_slot", 32'(want.frame_slot), 32'(result_bus.frame_slot));
        check_field("hit_count", want.hit_count, result_bus.hit_count);
      end
    end
  end

  // Waits until every queued word has been sent and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pages.size() != 0 || awaited_results.size() != 0);
  endtask

  task automatic write_limit(logic [cpr_pkg::LIMIT_W-1:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.frame_limit <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    frame_limit_reg = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Stimulus: directed sequences, then random phases over several limits.
  initial begin
    int unsigned              limits [9];
    bit [cpr_pkg::PAGE_W-1:0] one_frame [7];
    bit [cpr_pkg::PAGE_W-1:0] three_frames [14];
    int unsigned              usable;
    int unsigned              span;
    bit [cpr_pkg::PAGE_W-1:0] base;
    bit [cpr_pkg::PAGE_W-1:0] pg;

    limits = '{1, 2, 7, 16, 4, 40, 100, 255, 128};
    one_frame = '{0, 0, 127, 127, 0, 85, 42};
    three_frames = '{5, 6, 5, 6, 42, 100, 5, 6, 127, 0, 100, 42, 1, 126};

    rst = 1'b1;
    page_bus.valid = 1'b0;
    page_bus.page_number = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.frame_limit = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // A limit of zero behaves as a single frame: every miss after the first evicts.
    write_limit(0);
    foreach (one_frame[i]) pending_pages.push_back(one_frame[i]);

    // Three frames: fills, hits, and a sweep that clears every referenced bit.
    write_limit(3);
    foreach (three_frames[i]) pending_pages.push_back(three_frames[i]);

    // Random phases around a sliding working set, with some fully random pages.
    foreach (limits[i]) begin
      write_limit(cpr_pkg::LIMIT_W'(limits[i]));
      usable = (limits[i] > cpr_pkg::MAX_FRAMES) ? cpr_pkg::MAX_FRAMES : limits[i];
      span = ((frames_in_use > usable) ? frames_in_use : usable) + $urandom_range(1, 4);
      if (span > cpr_pkg::NUM_PAGES) span = cpr_pkg::NUM_PAGES;
      base = cpr_pkg::PAGE_W'($urandom_range(0, cpr_pkg::NUM_PAGES - 1));
      steady = (i == 3);
      repeat (147) begin
        if ($urandom_range(0, 99) < 20) begin
          pg = cpr_pkg::PAGE_W'($urandom_range(0, cpr_pkg::NUM_PAGES - 1));
        end else begin
          pg = base + cpr_pkg::PAGE_W'($urandom_range(0, span - 1));
        end
        pending_pages.push_back(pg);
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (140) @(posedge clk);
    if (errors == 0) begin
      $display("clock_page_replacement_test: PASS");
    end else begin
      $display("clock_page_replacement_test: FAIL");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #4_000_000;
    $display("clock_page_replacement_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cpr_pkg.sv
rtl/core/cpr_page_if.sv
rtl/core/cpr_result_if.sv
rtl/core/cpr_cfg_if.sv
rtl/core/cpr_ram.sv
rtl/core/cpr_ctrl.sv
rtl/core/cpr_datapath.sv
rtl/core/clock_page_replacement.sv
verif/clock_page_replacement_test.sv
